// File: rtl/pkt_pkg.sv
`timescale 1ns / 1ps
// Position Kalman tracker package: field widths, fixed-point constants, register indexes.
// No dependencies.
package pkt_pkg;

   localparam int POS_W = 32;
   localparam int VAR_W = 32;
   localparam int REV_W = 32;
   localparam int NOISE_W = 24;
   localparam int GAIN_W = 17;

   localparam logic [VAR_W-1:0] VAR_SEED = 32'd6553600;
   localparam logic [NOISE_W-1:0] QN_RESET = 24'd6554;
   localparam logic [NOISE_W-1:0] RN_RESET = 24'd65536;
   localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

   typedef enum logic [0:0] {
      CSR_PROCESS_NOISE = 1'b0,
      CSR_MEASUREMENT_NOISE = 1'b1
   } csr_index_type;

endpackage

// File: rtl/pkt_req_if.sv
`timescale 1ns / 1ps
// Measurement request channel: valid/ready plus one measurement item.
// Depends on pkt_pkg.
interface pkt_req_if;
   logic valid;
   logic ready;
   logic restart;
   logic signed [pkt_pkg::POS_W-1:0] meas_x;
   logic signed [pkt_pkg::POS_W-1:0] meas_y;
   logic [pkt_pkg::REV_W-1:0] revolution;

   modport source (output valid, restart, meas_x, meas_y, revolution, input ready);
   modport sink (input valid, restart, meas_x, meas_y, revolution, output ready);
endinterface

// File: rtl/pkt_rsp_if.sv
`timescale 1ns / 1ps
// Estimate response channel: valid/ready plus one estimate item.
// Depends on pkt_pkg.
interface pkt_rsp_if;
   logic valid;
   logic ready;
   logic signed [pkt_pkg::POS_W-1:0] est_x;
   logic signed [pkt_pkg::POS_W-1:0] est_y;
   logic [pkt_pkg::VAR_W-1:0] est_variance;
   logic tracking;

   modport source (output valid, est_x, est_y, est_variance, tracking, input ready);
   modport sink (input valid, est_x, est_y, est_variance, tracking, output ready);
endinterface

// File: rtl/pkt_csr_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready, register index and write data.
// Depends on pkt_pkg.
interface pkt_csr_if;
   logic valid;
   logic ready;
   pkt_pkg::csr_index_type index;
   logic [pkt_pkg::NOISE_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/position_kalman_tracker.sv
`timescale 1ns / 1ps
// Position Kalman tracker top level. Depends on pkt_pkg, pkt_req_if, pkt_rsp_if, pkt_csr_if.
// Flow: a restart or seeding transfer goes straight to S_DONE; a tracking update first runs
//   3 multiply/accumulate, 1 saturate, 17 restoring divide steps for the gain and 4
//   multiply/update steps. One item at a time; req ready again once the result is
//   registered; S_DONE holds while an earlier response is unaccepted. Shared 33x18 multiplier.
// Reset (synchronous): track cleared, variance 100.0, noise registers to defaults.
module position_kalman_tracker (
   input logic clock,
   input logic reset,
   pkt_req_if.sink req_ch,
   pkt_rsp_if.source rsp_ch,
   pkt_csr_if.sink csr_ch
);
   import pkt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MQ0, S_MQ1, S_MQ2, S_SAT, S_DIV, S_MX, S_MY, S_MP, S_VAR, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [NOISE_W-1:0] qn_ff, qn_in, rn_ff, rn_in;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [VAR_W-1:0] var_ff, var_in;
   logic [REV_W-1:0] last_rev_ff, last_rev_in;
   logic seeded_ff, seeded_in;

   logic signed [POS_W-1:0] meas_x_ff, meas_x_in, meas_y_ff, meas_y_in;
   logic [REV_W-1:0] rev_ff, rev_in, d_ff, d_in;
   logic signed [50:0] prod_ff, prod_in;
   logic [56:0] acc_ff, acc_in;
   logic [VAR_W-1:0] p_ff, p_in;
   logic [32:0] den_ff, den_in;
   logic [33:0] rem_ff, rem_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [4:0] cnt_ff, cnt_in;

   logic signed [POS_W-1:0] est_x_ff, est_x_in, est_y_ff, est_y_in;
   logic [VAR_W-1:0] est_var_ff, est_var_in;
   logic tracking_ff, tracking_in, rsp_valid_ff, rsp_valid_in;

   logic signed [32:0] mul_a, diff_x, diff_y;
   logic signed [17:0] mul_b;
   logic [50:0] rnd;
   logic [POS_W-1:0] step;
   logic [VAR_W-1:0] p_sat;
   logic [34:0] trial;
   logic ge;
   logic [33:0] new_r;
   logic req_xfer;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_xfer = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.est_x = est_x_ff;
   assign rsp_ch.est_y = est_y_ff;
   assign rsp_ch.est_variance = est_var_ff;
   assign rsp_ch.tracking = tracking_ff;

   assign diff_x = {meas_x_ff[POS_W-1], meas_x_ff} - {pos_x_ff[POS_W-1], pos_x_ff};
   assign diff_y = {meas_y_ff[POS_W-1], meas_y_ff} - {pos_y_ff[POS_W-1], pos_y_ff};

   // truncate toward zero on the /65536
   assign rnd = prod_ff + {35'b0, {16{prod_ff[50]}}};
   assign step = rnd[47:16];

   assign p_sat = (|acc_ff[56:32]) ? {VAR_W{1'b1}} : acc_ff[31:0];

   assign trial = {1'b0, rem_ff} - {2'b0, den_ff};
   assign ge = !trial[34];
   assign new_r = ge ? trial[33:0] : rem_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MQ0: begin
            mul_a = {1'b0, d_ff};
            mul_b = {2'b0, qn_ff[15:0]};
         end
         S_MQ1: begin
            mul_a = {1'b0, d_ff};
            mul_b = {10'b0, qn_ff[23:16]};
         end
         S_MX: begin
            mul_a = diff_x;
            mul_b = {1'b0, gain_ff};
         end
         S_MY: begin
            mul_a = diff_y;
            mul_b = {1'b0, gain_ff};
         end
         S_MP: begin
            mul_a = {1'b0, p_ff};
            mul_b = {1'b0, GAIN_ONE - gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = 51'(mul_a) * 51'(mul_b);
   end

   always_comb begin
      state_in = state_ff;
      qn_in = qn_ff;
      rn_in = rn_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      var_in = var_ff;
      last_rev_in = last_rev_ff;
      seeded_in = seeded_ff;
      meas_x_in = meas_x_ff;
      meas_y_in = meas_y_ff;
      rev_in = rev_ff;
      d_in = d_ff;
      acc_in = acc_ff;
      p_in = p_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      gain_in = gain_ff;
      cnt_in = cnt_ff;
      est_x_in = est_x_ff;
      est_y_in = est_y_ff;
      est_var_in = est_var_ff;
      tracking_in = tracking_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_PROCESS_NOISE: qn_in = csr_ch.data;
            CSR_MEASUREMENT_NOISE: rn_in = csr_ch.data;
            default: qn_in = qn_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               meas_x_in = req_ch.meas_x;
               meas_y_in = req_ch.meas_y;
               rev_in = req_ch.revolution;
               d_in = req_ch.revolution - last_rev_ff;
               if (req_ch.restart) begin
                  pos_x_in = '0;
                  pos_y_in = '0;
                  var_in = VAR_SEED;
                  last_rev_in = '0;
                  seeded_in = 1'b0;
                  state_in = S_DONE;
               end else if (!seeded_ff) begin
                  pos_x_in = req_ch.meas_x;
                  pos_y_in = req_ch.meas_y;
                  var_in = VAR_SEED;
                  last_rev_in = req_ch.revolution;
                  seeded_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_MQ0;
               end
            end
         end
         S_MQ0: state_in = S_MQ1;
         S_MQ1: begin
            acc_in = 57'(var_ff) + 57'(prod_ff[47:0]);
            state_in = S_MQ2;
         end
         S_MQ2: begin
            acc_in = acc_ff + {prod_ff[40:0], 16'b0};
            state_in = S_SAT;
         end
         S_SAT: begin
            p_in = p_sat;
            den_in = {1'b0, p_sat} + {9'b0, rn_ff};
            rem_in = {2'b0, p_sat};
            gain_in = '0;
            cnt_in = 5'd16;
            state_in = S_DIV;
         end
         S_DIV: begin
            gain_in = {gain_ff[GAIN_W-2:0], ge};
            rem_in = {new_r[32:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               if (den_ff == '0) begin
                  gain_in = '0;
               end
               state_in = S_MX;
            end
         end
         S_MX: state_in = S_MY;
         S_MY: begin
            pos_x_in = pos_x_ff + step;
            state_in = S_MP;
         end
         S_MP: begin
            pos_y_in = pos_y_ff + step;
            state_in = S_VAR;
         end
         S_VAR: begin
            var_in = prod_ff[47:16];
            last_rev_in = rev_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               est_x_in = pos_x_ff;
               est_y_in = pos_y_ff;
               est_var_in = var_ff;
               tracking_in = seeded_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      meas_x_ff <= meas_x_in;
      meas_y_ff <= meas_y_in;
      rev_ff <= rev_in;
      d_ff <= d_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      p_ff <= p_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      gain_ff <= gain_in;
      cnt_ff <= cnt_in;
      est_x_ff <= est_x_in;
      est_y_ff <= est_y_in;
      est_var_ff <= est_var_in;
      tracking_ff <= tracking_in;
      if (reset) begin
         state_ff <= S_IDLE;
         qn_ff <= QN_RESET;
         rn_ff <= RN_RESET;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         var_ff <= VAR_SEED;
         last_rev_ff <= '0;
         seeded_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         qn_ff <= qn_in;
         rn_ff <= rn_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         var_ff <= var_in;
         last_rev_ff <= last_rev_in;
         seeded_ff <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MX) |-> (gain_ff <= GAIN_ONE))
      else $error("gain above one");

   a_untracked_reset_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.tracking) |->
         (rsp_ch.est_x == '0 && rsp_ch.est_y == '0 && rsp_ch.est_variance == VAR_SEED))
      else $error("untracked result not at reset values");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != S_IDLE))
      else $error("request transfer did not start work");
`endif

endmodule
